/* rtl/core/masked_complex_elementwise_op_core_defines.svh */
// Assertion macros used by the top-level core RTL file.
`ifndef MASKED_COMPLEX_ELEMENTWISE_OP_CORE_DEFINES_SVH
`define MASKED_COMPLEX_ELEMENTWISE_OP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MCOP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCOP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCOP_ASSERT(lbl, clk, rst, prop, msg)
`define MCOP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/mcop_pkg.sv */
// Types, codes and helper functions of the masked complex element-wise core.
package mcop_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam int IDX_W          = 16;
   localparam int Q_W            = 32;
   localparam int Q_FRAC         = 28;
   localparam int DIV_STEPS      = 64 + Q_FRAC;
   localparam int PADDR_W        = 5;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_DZ  = 2'd2;

   localparam logic [2:0] REG_INDEX_MASK  = 3'd0;
   localparam logic [2:0] REG_INDEX_MATCH = 3'd1;
   localparam logic [2:0] REG_OP_KIND     = 3'd2;
   localparam logic [2:0] REG_SUCC_RE     = 3'd3;
   localparam logic [2:0] REG_SUCC_IM     = 3'd4;
   localparam logic [2:0] REG_FAIL_RE     = 3'd5;
   localparam logic [2:0] REG_FAIL_IM     = 3'd6;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_ONE = 32'h1000_0000;

   typedef struct packed {
      logic [15:0]        index_mask;
      logic [15:0]        index_match;
      logic [1:0]         op_kind;
      logic signed [31:0] succ_re;
      logic signed [31:0] succ_im;
      logic signed [31:0] fail_re;
      logic signed [31:0] fail_im;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic        is_div;
      logic        neg_re;
      logic        neg_im;
      logic [31:0] fix_re;
      logic [31:0] fix_im;
      logic [1:0]  fix_status;
   } pass_type;

   typedef struct packed {
      logic [63:0] den;
      logic [63:0] rem_re;
      logic [63:0] rem_im;
      logic [63:0] num_re;
      logic [63:0] num_im;
      logic [31:0] q_re;
      logic [31:0] q_im;
      logic        over_re;
      logic        over_im;
   } div_type;

   typedef struct packed {
      logic [31:0] val;
      logic        clip;
   } sat_type;

   function automatic sat_type sat37(input logic signed [36:0] v);
      sat_type r;
      begin
         r.clip = 1'b1;
         if (v > 37'sd2147483647) begin
            r.val = Q_MAX;
         end else if (v < -37'sd2147483648) begin
            r.val = Q_MIN;
         end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
         end
         return r;
      end
   endfunction

   function automatic logic [31:0] sign_sat(input logic signed [31:0] v);
      logic [31:0] r;
      begin
         if (v[31]) begin
            r = Q_MIN;
         end else if (v != 32'sd0) begin
            r = Q_MAX;
         end else begin
            r = '0;
         end
         return r;
      end
   endfunction

endpackage

/* rtl/core/masked_complex_elementwise_op_core.sv */
// Top level: register port, front stages, divider cell chain and result register.
// Takes one item per clock unless the output stalls and returns one result per item, in
// order. The path is four front stages (select, multiply, sum, round), a chain of
// 92 division cells that each produce one quotient bit for both components, and
// the result register. Every operation passes through the whole chain. A stall on
// rsp_tready holds the entire pipeline and drops req_tready in the same cycle.
`include "masked_complex_elementwise_op_core_defines.svh"
module masked_complex_elementwise_op_core #(
   parameter int INDEX_BITS = mcop_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // elem_re[31:0], elem_im[63:32], row_index[79:64], col_index[95:80]
   input  logic [95:0]                   req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // res_re[31:0], res_im[63:32]
   output logic [63:0]                   rsp_tdata,
   // took_success[0], status[2:1]
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mcop_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int STEPS = mcop_pkg::DIV_STEPS;

   mcop_pkg::cfg_type cfg_ff;
   logic              csr_we;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.index_mask  <= '0;
         cfg_ff.index_match <= '0;
         cfg_ff.op_kind     <= mcop_pkg::OP_MUL;
         cfg_ff.succ_re     <= mcop_pkg::Q_ONE;
         cfg_ff.succ_im     <= '0;
         cfg_ff.fail_re     <= '0;
         cfg_ff.fail_im     <= '0;
      end else if (csr_we) begin
         case (reg_idx)
            mcop_pkg::REG_INDEX_MASK:  cfg_ff.index_mask  <= csr_pwdata[15:0];
            mcop_pkg::REG_INDEX_MATCH: cfg_ff.index_match <= csr_pwdata[15:0];
            mcop_pkg::REG_OP_KIND:     cfg_ff.op_kind     <= csr_pwdata[1:0];
            mcop_pkg::REG_SUCC_RE:     cfg_ff.succ_re     <= csr_pwdata;
            mcop_pkg::REG_SUCC_IM:     cfg_ff.succ_im     <= csr_pwdata;
            mcop_pkg::REG_FAIL_RE:     cfg_ff.fail_re     <= csr_pwdata;
            mcop_pkg::REG_FAIL_IM:     cfg_ff.fail_im     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mcop_pkg::REG_INDEX_MASK:  csr_prdata = {16'd0, cfg_ff.index_mask};
         mcop_pkg::REG_INDEX_MATCH: csr_prdata = {16'd0, cfg_ff.index_match};
         mcop_pkg::REG_OP_KIND:     csr_prdata = {30'd0, cfg_ff.op_kind};
         mcop_pkg::REG_SUCC_RE:     csr_prdata = cfg_ff.succ_re;
         mcop_pkg::REG_SUCC_IM:     csr_prdata = cfg_ff.succ_im;
         mcop_pkg::REG_FAIL_RE:     csr_prdata = cfg_ff.fail_re;
         mcop_pkg::REG_FAIL_IM:     csr_prdata = cfg_ff.fail_im;
         default:                   csr_prdata = '0;
      endcase
   end

   logic rsp_valid_ff;
   logic adv;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   mcop_pkg::pass_type pass_chain [0:STEPS];
   mcop_pkg::div_type  div_chain  [0:STEPS];

   mcop_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .elem_re   (req_tdata[31:0]),
      .elem_im   (req_tdata[63:32]),
      .row_index (req_tdata[79:64]),
      .col_index (req_tdata[95:80]),
      .cfg       (cfg_ff),
      .pass_out  (pass_chain[0]),
      .div_out   (div_chain[0])
   );

   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      mcop_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .pass_in  (pass_chain[g]),
         .div_in   (div_chain[g]),
         .pass_out (pass_chain[g+1]),
         .div_out  (div_chain[g+1])
      );
   end

   mcop_pkg::pass_type last_p;
   mcop_pkg::div_type  last_d;
   logic               clip_re, clip_im;
   logic [31:0]        res_re_in, res_im_in, res_re_ff, res_im_ff;
   logic [1:0]         status_in, status_ff;
   logic               ok_ff;

   assign last_p = pass_chain[STEPS];
   assign last_d = div_chain[STEPS];

   always_comb begin
      res_re_in = last_p.fix_re;
      res_im_in = last_p.fix_im;
      status_in = last_p.fix_status;
      clip_re   = 1'b0;
      clip_im   = 1'b0;
      if (last_p.is_div) begin
         if (last_p.neg_re) begin
            clip_re   = last_d.over_re || (last_d.q_re[31] && (|last_d.q_re[30:0]));
            res_re_in = clip_re ? mcop_pkg::Q_MIN : 32'(-last_d.q_re);
         end else begin
            clip_re   = last_d.over_re || last_d.q_re[31];
            res_re_in = clip_re ? mcop_pkg::Q_MAX : last_d.q_re;
         end
         if (last_p.neg_im) begin
            clip_im   = last_d.over_im || (last_d.q_im[31] && (|last_d.q_im[30:0]));
            res_im_in = clip_im ? mcop_pkg::Q_MIN : 32'(-last_d.q_im);
         end else begin
            clip_im   = last_d.over_im || last_d.q_im[31];
            res_im_in = clip_im ? mcop_pkg::Q_MAX : last_d.q_im;
         end
         status_in = (clip_re || clip_im) ? mcop_pkg::STATUS_SAT : mcop_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last_p.valid;
      end
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
         ok_ff     <= last_p.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_im_ff, res_re_ff};
   assign rsp_tuser  = {status_ff, ok_ff};

   `MCOP_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> (rsp_tuser[2:1] != 2'd3), "bad status code")
   `MCOP_ASSERT(a_dz_value, clock, reset, (rsp_tvalid && (rsp_tuser[2:1] == mcop_pkg::STATUS_DZ)) |-> ((rsp_tdata[31:0] == mcop_pkg::Q_MAX) || (rsp_tdata[31:0] == mcop_pkg::Q_MIN) || (rsp_tdata[31:0] == 32'd0)), "divide by zero result not a limit")
   `MCOP_ASSERT(a_drain, clock, reset, (rsp_tvalid && rsp_tready && !last_p.valid) |=> !rsp_tvalid, "result shown without item")
   `MCOP_ASSERT(a_ready, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready, "input taken during stall")

endmodule

/* rtl/core/mcop_front.sv */
// Index test, coefficient select, add/subtract, products, sums and rounding ahead of the divider chain.
module mcop_front #(
   parameter int INDEX_BITS = mcop_pkg::INDEX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [31:0]  elem_re,
   input  logic signed [31:0]  elem_im,
   input  logic [15:0]         row_index,
   input  logic [15:0]         col_index,
   input  mcop_pkg::cfg_type   cfg,
   output mcop_pkg::pass_type  pass_out,
   output mcop_pkg::div_type   div_out
);

   localparam logic [15:0] LIM = (INDEX_BITS >= 16) ? 16'hFFFF :
                                 16'((32'd1 << INDEX_BITS) - 32'd1);

   // select stage
   logic               v0_ff, ok0_ff;
   logic signed [31:0] er_ff, ei_ff, cr_ff, ci_ff;
   logic [15:0]        msk;
   logic               ok_in;

   assign msk   = cfg.index_mask & LIM;
   assign ok_in = ((row_index & LIM & msk) == cfg.index_match) &&
                  ((col_index & LIM & msk) == cfg.index_match);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
      if (adv) begin
         ok0_ff <= ok_in;
         er_ff  <= elem_re;
         ei_ff  <= elem_im;
         cr_ff  <= ok_in ? cfg.succ_re : cfg.fail_re;
         ci_ff  <= ok_in ? cfg.succ_im : cfg.fail_im;
      end
   end

   // product stage
   logic               v1_ff, ok1_ff, dz1_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic [31:0]        fix_re1_in, fix_im1_in, fix_re1_ff, fix_im1_ff;
   logic [1:0]         fst1_in, fst1_ff;
   logic signed [32:0] add_re, add_im, sub_re, sub_im;
   mcop_pkg::sat_type  s_re, s_im;
   logic               dz_in;

   assign add_re = 33'(er_ff) + 33'(cr_ff);
   assign add_im = 33'(ei_ff) + 33'(ci_ff);
   assign sub_re = 33'(er_ff) - 33'(cr_ff);
   assign sub_im = 33'(ei_ff) - 33'(ci_ff);
   assign dz_in  = (cr_ff == 32'sd0) && (ci_ff == 32'sd0);

   always_comb begin
      s_re = mcop_pkg::sat37(37'(add_re));
      s_im = mcop_pkg::sat37(37'(add_im));
      case (cfg.op_kind)
         mcop_pkg::OP_ADD: begin
            s_re = mcop_pkg::sat37(37'(add_re));
            s_im = mcop_pkg::sat37(37'(add_im));
         end
         mcop_pkg::OP_SUB: begin
            s_re = mcop_pkg::sat37(37'(sub_re));
            s_im = mcop_pkg::sat37(37'(sub_im));
         end
         default: begin
            s_re = mcop_pkg::sat37(37'(add_re));
            s_im = mcop_pkg::sat37(37'(add_im));
         end
      endcase
      if (cfg.op_kind == mcop_pkg::OP_ADD || cfg.op_kind == mcop_pkg::OP_SUB) begin
         fix_re1_in = s_re.val;
         fix_im1_in = s_im.val;
         fst1_in    = (s_re.clip || s_im.clip) ? mcop_pkg::STATUS_SAT : mcop_pkg::STATUS_OK;
      end else begin
         fix_re1_in = mcop_pkg::sign_sat(er_ff);
         fix_im1_in = mcop_pkg::sign_sat(ei_ff);
         fst1_in    = mcop_pkg::STATUS_DZ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
      if (adv) begin
         ok1_ff     <= ok0_ff;
         dz1_ff     <= dz_in;
         p_rr_ff    <= er_ff * cr_ff;
         p_ii_ff    <= ei_ff * ci_ff;
         p_ri_ff    <= er_ff * ci_ff;
         p_ir_ff    <= ei_ff * cr_ff;
         sq_r_ff    <= cr_ff * cr_ff;
         sq_i_ff    <= ci_ff * ci_ff;
         fix_re1_ff <= fix_re1_in;
         fix_im1_ff <= fix_im1_in;
         fst1_ff    <= fst1_in;
      end
   end

   // sum stage
   logic               v2_ff, ok2_ff, dz2_ff;
   logic signed [64:0] sr_ff, si_ff;
   logic [63:0]        den2_ff;
   logic [31:0]        fix_re2_ff, fix_im2_ff;
   logic [1:0]         fst2_ff;
   logic               div_sel;

   assign div_sel = (cfg.op_kind == mcop_pkg::OP_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         ok2_ff     <= ok1_ff;
         dz2_ff     <= dz1_ff;
         sr_ff      <= div_sel ? 65'(p_rr_ff) + 65'(p_ii_ff) : 65'(p_rr_ff) - 65'(p_ii_ff);
         si_ff      <= div_sel ? 65'(p_ir_ff) - 65'(p_ri_ff) : 65'(p_ri_ff) + 65'(p_ir_ff);
         den2_ff    <= 64'($unsigned(sq_r_ff)) + 64'($unsigned(sq_i_ff));
         fix_re2_ff <= fix_re1_ff;
         fix_im2_ff <= fix_im1_ff;
         fst2_ff    <= fst1_ff;
      end
   end

   // round and magnitude stage
   mcop_pkg::pass_type pass_in, pass_ff;
   mcop_pkg::div_type  div_in, div_ff;
   mcop_pkg::sat_type  m_re, m_im;
   logic signed [64:0] nr, ni;

   assign nr = -sr_ff;
   assign ni = -si_ff;

   always_comb begin
      m_re = mcop_pkg::sat37($signed(sr_ff[64:28]));
      m_im = mcop_pkg::sat37($signed(si_ff[64:28]));
      pass_in.valid      = v2_ff;
      pass_in.ok         = ok2_ff;
      pass_in.is_div     = div_sel && !dz2_ff;
      pass_in.neg_re     = sr_ff[64];
      pass_in.neg_im     = si_ff[64];
      pass_in.fix_re     = fix_re2_ff;
      pass_in.fix_im     = fix_im2_ff;
      pass_in.fix_status = fst2_ff;
      if (cfg.op_kind == mcop_pkg::OP_MUL) begin
         pass_in.fix_re     = m_re.val;
         pass_in.fix_im     = m_im.val;
         pass_in.fix_status = (m_re.clip || m_im.clip) ? mcop_pkg::STATUS_SAT
                                                       : mcop_pkg::STATUS_OK;
      end
      div_in.den     = den2_ff;
      div_in.rem_re  = '0;
      div_in.rem_im  = '0;
      div_in.num_re  = sr_ff[64] ? nr[63:0] : sr_ff[63:0];
      div_in.num_im  = si_ff[64] ? ni[63:0] : si_ff[63:0];
      div_in.q_re    = '0;
      div_in.q_im    = '0;
      div_in.over_re = 1'b0;
      div_in.over_im = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff.valid <= 1'b0;
      end else if (adv) begin
         pass_ff.valid <= pass_in.valid;
      end
      if (adv) begin
         pass_ff.ok         <= pass_in.ok;
         pass_ff.is_div     <= pass_in.is_div;
         pass_ff.neg_re     <= pass_in.neg_re;
         pass_ff.neg_im     <= pass_in.neg_im;
         pass_ff.fix_re     <= pass_in.fix_re;
         pass_ff.fix_im     <= pass_in.fix_im;
         pass_ff.fix_status <= pass_in.fix_status;
         div_ff             <= div_in;
      end
   end

   assign pass_out = pass_ff;
   assign div_out  = div_ff;

endmodule

/* rtl/core/mcop_div_cell.sv */
// One restoring-division step for both components, with item payload hand-off.
module mcop_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  mcop_pkg::pass_type pass_in,
   input  mcop_pkg::div_type  div_in,
   output mcop_pkg::pass_type pass_out,
   output mcop_pkg::div_type  div_out
);

   mcop_pkg::pass_type pass_ff;
   mcop_pkg::div_type  div_ff, div_nx;
   logic [64:0]        t_re, t_im;
   logic               ge_re, ge_im;

   assign t_re  = {div_in.rem_re, div_in.num_re[63]};
   assign t_im  = {div_in.rem_im, div_in.num_im[63]};
   assign ge_re = t_re >= {1'b0, div_in.den};
   assign ge_im = t_im >= {1'b0, div_in.den};

   always_comb begin
      div_nx         = div_in;
      div_nx.rem_re  = ge_re ? 64'(t_re - {1'b0, div_in.den}) : t_re[63:0];
      div_nx.rem_im  = ge_im ? 64'(t_im - {1'b0, div_in.den}) : t_im[63:0];
      div_nx.num_re  = {div_in.num_re[62:0], 1'b0};
      div_nx.num_im  = {div_in.num_im[62:0], 1'b0};
      div_nx.q_re    = {div_in.q_re[30:0], ge_re};
      div_nx.q_im    = {div_in.q_im[30:0], ge_im};
      div_nx.over_re = div_in.over_re | div_in.q_re[31];
      div_nx.over_im = div_in.over_im | div_in.q_im[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff.valid <= 1'b0;
      end else if (adv) begin
         pass_ff.valid <= pass_in.valid;
      end
      if (adv) begin
         pass_ff.ok         <= pass_in.ok;
         pass_ff.is_div     <= pass_in.is_div;
         pass_ff.neg_re     <= pass_in.neg_re;
         pass_ff.neg_im     <= pass_in.neg_im;
         pass_ff.fix_re     <= pass_in.fix_re;
         pass_ff.fix_im     <= pass_in.fix_im;
         pass_ff.fix_status <= pass_in.fix_status;
         div_ff             <= div_nx;
      end
   end

   assign pass_out = pass_ff;
   assign div_out  = div_ff;

endmodule

/* tb/masked_complex_elementwise_op_core_tb.sv */
// Testbench for the masked complex element-wise core: streams elements, predicts, checks.
module masked_complex_elementwise_op_core_tb;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [31:0] im;
      logic [31:0] re;
   } elem_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        took;
      logic [31:0] im;
      logic [31:0] re;
   } res_type;

   logic        clock;
   logic        reset;
   logic [95:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [mcop_pkg::PADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   masked_complex_elementwise_op_core i_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mcop_pkg::cfg_type cfg_mirror;
   elem_type    pending_elems[$];
   res_type     expected_results[$];
   int          req_gap;
   int          rsp_stall;
   bit          no_idle;
   int          errors;
   int          accepted;
   int          checked;
   int          cycles;
   int          n_dz;
   int          n_sat;
   int          n_succ;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] sat_q(input logic signed [127:0] v, inout bit clip);
      logic [31:0] r;
      if (v > 128'sd2147483647) begin
         clip = 1'b1;
         r = mcop_pkg::Q_MAX;
      end else if (v < -128'sd2147483648) begin
         clip = 1'b1;
         r = mcop_pkg::Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sign_sat_tb(input logic [31:0] v);
      if (v[31]) return mcop_pkg::Q_MIN;
      if (v != 32'd0) return mcop_pkg::Q_MAX;
      return 32'd0;
   endfunction

   function automatic res_type compute_elem(input elem_type e, input mcop_pkg::cfg_type c);
      res_type r;
      logic signed [127:0] er, ei, cr, ci, vr, vi, den, mag_r, mag_i, q_r, q_i;
      logic [15:0] m;
      bit clip;
      clip = 1'b0;
      m = c.index_mask;
      r.took = ((e.row & m) == c.index_match) && ((e.col & m) == c.index_match);
      r.status = mcop_pkg::STATUS_OK;
      er = $signed(e.re);
      ei = $signed(e.im);
      cr = r.took ? $signed(c.succ_re) : $signed(c.fail_re);
      ci = r.took ? $signed(c.succ_im) : $signed(c.fail_im);
      case (c.op_kind)
         mcop_pkg::OP_ADD: begin
            r.re = sat_q(er + cr, clip);
            r.im = sat_q(ei + ci, clip);
         end
         mcop_pkg::OP_SUB: begin
            r.re = sat_q(er - cr, clip);
            r.im = sat_q(ei - ci, clip);
         end
         mcop_pkg::OP_MUL: begin
            vr = er * cr - ei * ci;
            vi = er * ci + ei * cr;
            r.re = sat_q(vr >>> mcop_pkg::Q_FRAC, clip);
            r.im = sat_q(vi >>> mcop_pkg::Q_FRAC, clip);
         end
         default: begin
            if (cr == 0 && ci == 0) begin
               r.re = sign_sat_tb(e.re);
               r.im = sign_sat_tb(e.im);
               r.status = mcop_pkg::STATUS_DZ;
            end else begin
               den = cr * cr + ci * ci;
               vr = er * cr + ei * ci;
               vi = ei * cr - er * ci;
               mag_r = vr < 0 ? -vr : vr;
               mag_i = vi < 0 ? -vi : vi;
               q_r = (mag_r <<< mcop_pkg::Q_FRAC) / den;
               q_i = (mag_i <<< mcop_pkg::Q_FRAC) / den;
               r.re = sat_q(vr < 0 ? -q_r : q_r, clip);
               r.im = sat_q(vi < 0 ? -q_i : q_i, clip);
            end
         end
      endcase
      if (r.status == mcop_pkg::STATUS_OK && clip) r.status = mcop_pkg::STATUS_SAT;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_elem(elem_type'(req_tdata), cfg_mirror));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_elems.size() > 0) begin
               req_tdata  <= pending_elems.pop_front();
               req_tvalid <= 1'b1;
               req_gap    <= no_idle ? 0 : $urandom_range(0, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      res_type got, want;
      int s;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[2:1], rsp_tuser[0], rsp_tdata[63:32], rsp_tdata[31:0]};
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (want.status == mcop_pkg::STATUS_DZ) n_dz++;
               if (want.status == mcop_pkg::STATUS_SAT) n_sat++;
               if (want.took) n_succ++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"result %0d: expected re %h im %h took %b status %0d, ",
                               "got re %h im %h took %b status %0d"},
                              checked, want.re, want.im, want.took, want.status,
                              got.re, got.im, got.took, got.status);
               end
            end
            s = no_idle ? 0 : $urandom_range(0, 5);
            rsp_stall  <= s;
            rsp_tready <= (s == 0);
         end else if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= (rsp_stall == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("masked_complex_elementwise_op_core: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mcop_pkg::PADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         mcop_pkg::REG_INDEX_MASK:  cfg_mirror.index_mask  = value[15:0];
         mcop_pkg::REG_INDEX_MATCH: cfg_mirror.index_match = value[15:0];
         mcop_pkg::REG_OP_KIND:     cfg_mirror.op_kind     = value[1:0];
         mcop_pkg::REG_SUCC_RE:     cfg_mirror.succ_re     = value;
         mcop_pkg::REG_SUCC_IM:     cfg_mirror.succ_im     = value;
         mcop_pkg::REG_FAIL_RE:     cfg_mirror.fail_re     = value;
         default:                   cfg_mirror.fail_im     = value;
      endcase
   endtask

   function automatic logic [31:0] draw_q(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 3) == 0 ? mcop_pkg::Q_MIN : mcop_pkg::Q_MAX;
         2: return 32'd0;
         default: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      endcase
   endfunction

   function automatic elem_type draw_elem(input mcop_pkg::cfg_type c);
      elem_type e;
      int k;
      k = $urandom_range(0, 9);
      e.re = k < 4 ? $urandom : (k < 8 ? draw_q(3) : draw_q($urandom_range(0, 2)));
      e.im = k < 4 ? $urandom : (k < 8 ? draw_q(3) : draw_q($urandom_range(0, 2)));
      e.row = 16'($urandom);
      e.col = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         e.row = (e.row & ~c.index_mask) | (c.index_match & c.index_mask);
         e.col = (e.col & ~c.index_mask) | (c.index_match & c.index_mask);
      end
      return e;
   endfunction

   task automatic drain;
      wait (pending_elems.size() == 0 && !req_tvalid && expected_results.size() == 0);
      @(posedge clock);
   endtask

   initial begin
      elem_type e;
      int kind;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      no_idle = 1'b0;
      cfg_mirror = '{16'd0, 16'd0, mcop_pkg::OP_MUL, mcop_pkg::Q_ONE, 32'd0, 32'd0, 32'd0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes of each field
      pending_elems.push_back('{16'hFFFF, 16'hFFFF, mcop_pkg::Q_MAX, mcop_pkg::Q_MAX});
      pending_elems.push_back('{16'h0000, 16'h0000, mcop_pkg::Q_MIN, mcop_pkg::Q_MIN});
      pending_elems.push_back('{16'h1234, 16'hFFFF, 32'd0, mcop_pkg::Q_ONE});
      drain();
      csr_write(mcop_pkg::REG_OP_KIND, 32'(mcop_pkg::OP_DIV));
      csr_write(mcop_pkg::REG_SUCC_RE, 32'd0);
      pending_elems.push_back('{16'd0, 16'd0, mcop_pkg::Q_MIN, mcop_pkg::Q_MAX});
      pending_elems.push_back('{16'd0, 16'd0, 32'd0, 32'd1});
      drain();
      csr_write(mcop_pkg::REG_SUCC_RE, mcop_pkg::Q_MIN);
      csr_write(mcop_pkg::REG_SUCC_IM, mcop_pkg::Q_MIN);
      csr_write(mcop_pkg::REG_FAIL_RE, 32'd1);
      csr_write(mcop_pkg::REG_FAIL_IM, 32'd0);
      csr_write(mcop_pkg::REG_INDEX_MASK, 32'h0000_00F0);
      csr_write(mcop_pkg::REG_INDEX_MATCH, 32'h0000_0100);
      pending_elems.push_back('{16'h0100, 16'h0100, mcop_pkg::Q_MAX, mcop_pkg::Q_MIN});
      pending_elems.push_back('{16'h0000, 16'h0000, mcop_pkg::Q_MIN, mcop_pkg::Q_MAX});
      pending_elems.push_back('{16'h0000, 16'h0000, 32'd5, mcop_pkg::Q_MAX});
      drain();
      csr_write(mcop_pkg::REG_INDEX_MATCH, 32'h0000_0030);
      for (int op = 0; op < 4; op++) begin
         csr_write(mcop_pkg::REG_OP_KIND, 32'(op));
         pending_elems.push_back('{16'h0F3F, 16'h0030, mcop_pkg::Q_MAX, mcop_pkg::Q_MAX});
         pending_elems.push_back('{16'h0030, 16'h0031, mcop_pkg::Q_MIN, mcop_pkg::Q_MIN});
         pending_elems.push_back('{16'h0031, 16'h0030, mcop_pkg::Q_ONE, mcop_pkg::Q_MIN});
         pending_elems.push_back('{16'hFFFF, 16'hFFFF, 32'hF000_0000, 32'd7});
         drain();
      end

      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         kind = ph < 4 ? 3 : (ph < 7 ? $urandom_range(0, 1) : $urandom_range(0, 3));
         csr_write(mcop_pkg::REG_OP_KIND, 32'(ph % 4));
         csr_write(mcop_pkg::REG_INDEX_MASK,
                   ph == 5 ? 32'h0000_FFFF : (ph == 6 ? 32'd0 : $urandom));
         csr_write(mcop_pkg::REG_INDEX_MATCH, $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
         csr_write(mcop_pkg::REG_SUCC_RE, draw_q(kind));
         csr_write(mcop_pkg::REG_SUCC_IM, draw_q(kind));
         csr_write(mcop_pkg::REG_FAIL_RE, ph == 7 ? 32'd0 : draw_q(kind));
         csr_write(mcop_pkg::REG_FAIL_IM, ph == 7 ? 32'd0 : draw_q(kind));
         if (cfg_mirror.index_match != 0)
            csr_write(mcop_pkg::REG_INDEX_MATCH,
                      32'(cfg_mirror.index_match & cfg_mirror.index_mask));
         for (int n = 0; n < 58; n++) begin
            e = draw_elem(cfg_mirror);
            pending_elems.push_back(e);
         end
         drain();
      end

      repeat (120) @(posedge clock);
      $display("covered %0d elements over all four operations, %0d on the success path,",
               checked, n_succ);
      $display("%0d saturated, %0d with a zero divisor", n_sat, n_dz);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("masked_complex_elementwise_op_core: match");
      end else begin
         $display("masked_complex_elementwise_op_core: mismatch");
      end
      $finish;
   end

endmodule
